// ===== hw/rtl/whp_pkg.sv =====
`timescale 1ns / 1ps

package whp_pkg;

  // Status codes reported with every result item.
  typedef enum logic [2:0] {
    StHeader  = 3'd0,
    StPayload = 3'd1,
    StDone    = 3'd2,
    StNoRiff  = 3'd3,
    StNoWave  = 3'd4,
    StFmtSize = 3'd5,
    StNonPcm  = 3'd6,
    StNoData  = 3'd7
  } status_e;

  // Expected header words, little-endian as they appear in the shift register.
  localparam logic [31:0] TagRiff      = 32'h4646_4952;
  localparam logic [31:0] TagWave      = 32'h4556_4157;
  localparam logic [31:0] TagData      = 32'h6174_6164;
  localparam logic [31:0] FmtChunkSize = 32'd16;
  localparam logic [15:0] FmtPcm       = 16'd1;

  // Header byte offsets at which a field is complete.
  localparam logic [5:0] OffRiff     = 6'd3;
  localparam logic [5:0] OffWave     = 6'd11;
  localparam logic [5:0] OffFmtSize  = 6'd19;
  localparam logic [5:0] OffFormat   = 6'd21;
  localparam logic [5:0] OffChannels = 6'd23;
  localparam logic [5:0] OffRate     = 6'd27;
  localparam logic [5:0] OffBits     = 6'd35;
  localparam logic [5:0] OffData     = 6'd39;
  localparam logic [5:0] OffLast     = 6'd43;

  // One result item as it travels from the parser to the output buffer.
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        last_payload;
    status_e     status;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [31:0] data_size;
  } result_t;

endpackage

// ===== hw/rtl/whp_parse.sv =====
`timescale 1ns / 1ps

module whp_parse (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       byte_i,
  input  logic             sof_i,
  output whp_pkg::result_t result_o
);
  import whp_pkg::*;

  logic [5:0]  offset_q, offset_d, offset_eff;
  logic [31:0] word_q, word_d, word_eff;
  logic [15:0] chan_q, chan_d, chan_eff;
  logic [31:0] rate_q, rate_d, rate_eff;
  logic [15:0] bits_q, bits_d, bits_eff;
  logic [31:0] size_q, size_d, size_eff;
  logic [31:0] left_q, left_d, left_eff;
  status_e     status_q, status_d, status_eff;
  logic [31:0] word_new;
  logic        pvalid;
  logic [7:0]  pbyte;
  logic        plast;

  // A start of file clears the parse state before this byte is used.
  always_comb begin
    if (sof_i) begin
      offset_eff = '0;
      word_eff   = '0;
      chan_eff   = '0;
      rate_eff   = '0;
      bits_eff   = '0;
      size_eff   = '0;
      left_eff   = '0;
      status_eff = StHeader;
    end else begin
      offset_eff = offset_q;
      word_eff   = word_q;
      chan_eff   = chan_q;
      rate_eff   = rate_q;
      bits_eff   = bits_q;
      size_eff   = size_q;
      left_eff   = left_q;
      status_eff = status_q;
    end
  end

  // Header checks and field capture, then payload pass-through.
  always_comb begin
    word_new = {byte_i, word_eff[31:8]};
    offset_d = offset_eff;
    word_d   = word_eff;
    chan_d   = chan_eff;
    rate_d   = rate_eff;
    bits_d   = bits_eff;
    size_d   = size_eff;
    left_d   = left_eff;
    status_d = status_eff;
    pvalid   = 1'b0;
    pbyte    = '0;
    plast    = 1'b0;
    unique case (status_eff)
      StHeader: begin
        word_d = word_new;
        unique case (offset_eff)
          OffRiff:     if (word_new != TagRiff) status_d = StNoRiff;
          OffWave:     if (word_new != TagWave) status_d = StNoWave;
          OffFmtSize:  if (word_new != FmtChunkSize) status_d = StFmtSize;
          OffFormat:   if (word_new[31:16] != FmtPcm) status_d = StNonPcm;
          OffChannels: chan_d = word_new[31:16];
          OffRate:     rate_d = word_new;
          OffBits:     bits_d = word_new[31:16];
          OffData:     if (word_new != TagData) status_d = StNoData;
          OffLast: begin
            size_d   = word_new;
            left_d   = word_new;
            status_d = (word_new == '0) ? StDone : StPayload;
          end
          default: ;
        endcase
        if (offset_eff < OffLast) begin
          offset_d = offset_eff + 6'd1;
        end
      end
      StPayload: begin
        pvalid = 1'b1;
        pbyte  = byte_i;
        left_d = left_eff - 32'd1;
        if (left_eff == 32'd1) begin
          plast    = 1'b1;
          status_d = StDone;
        end
      end
      default: ;
    endcase
  end

  // Control state is cleared on reset; captured fields follow it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      word_q   <= '0;
      chan_q   <= '0;
      rate_q   <= '0;
      bits_q   <= '0;
      size_q   <= '0;
      left_q   <= '0;
      status_q <= StHeader;
    end else if (fire_i) begin
      offset_q <= offset_d;
      word_q   <= word_d;
      chan_q   <= chan_d;
      rate_q   <= rate_d;
      bits_q   <= bits_d;
      size_q   <= size_d;
      left_q   <= left_d;
      status_q <= status_d;
    end
  end

  // The result item reports the state after this byte.
  always_comb begin
    result_o.payload_valid = pvalid;
    result_o.payload_byte  = pbyte;
    result_o.last_payload  = plast;
    result_o.status        = status_d;
    result_o.channel_count = chan_d;
    result_o.sample_rate   = rate_d;
    result_o.sample_bits   = bits_d;
    result_o.data_size     = size_d;
  end

endmodule

// ===== hw/rtl/whp_rbuf.sv =====
`timescale 1ns / 1ps

module whp_rbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  whp_pkg::result_t data_i,
  output logic             space_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output whp_pkg::result_t data_o
);
  import whp_pkg::*;

  result_t    entry_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q;
  logic       pop;

  // Space is taken from the registered count only, so the receiver's
  // ready never reaches the input side in the same cycle.
  assign space_o     = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign data_o      = entry_q[rd_q];

  // Two-entry result queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/wav_header_parser.sv =====
`timescale 1ns / 1ps

// WAV header parser with payload pass-through.
// The input channel (in_valid_i / in_ready_o) takes one byte of a WAV file
// per item, with start_of_file_i marking header offset zero. The output
// channel (out_valid_o / out_ready_i) returns exactly one result item per
// input item: the payload byte when it is audio data, a last flag on the
// final payload byte, the parse status and the captured header fields.
// An accepted item is held in the input register, runs through the
// parser and lands in a two-entry result queue, from which its result is
// offered. With the receiver ready the block takes one item every cycle;
// the rate is set by the single parser pass per byte.
// When the receiver stalls, the queue fills with two items and the input
// register holds a third, after which in_ready_o drops until an item is
// taken. in_ready_o is derived from registers only.
// Reset clears the queue and puts the parser at header offset zero with
// all captured fields at zero, as if a start of file had been seen.

module wav_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        start_of_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        payload_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_payload_o,
  output logic [2:0]  status_o,
  output logic [15:0] channel_count_o,
  output logic [31:0] sample_rate_o,
  output logic [15:0] sample_bits_o,
  output logic [31:0] data_size_o
);
  import whp_pkg::*;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_sof_q;
  logic       in_fire;
  logic       s1_fire;
  logic       buf_space;
  result_t    parse_res;
  result_t    out_res;

  assign in_ready_o = !s1_valid_q || buf_space;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_fire    = s1_valid_q && buf_space;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= byte_value_i;
      s1_sof_q  <= start_of_file_i;
    end
  end

  whp_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s1_fire),
    .byte_i   (s1_byte_q),
    .sof_i    (s1_sof_q),
    .result_o (parse_res)
  );

  whp_rbuf u_rbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_fire),
    .data_i      (parse_res),
    .space_o     (buf_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (out_res)
  );

  assign payload_valid_o = out_res.payload_valid;
  assign payload_byte_o  = out_res.payload_byte;
  assign last_payload_o  = out_res.last_payload;
  assign status_o        = out_res.status;
  assign channel_count_o = out_res.channel_count;
  assign sample_rate_o   = out_res.sample_rate;
  assign sample_bits_o   = out_res.sample_bits;
  assign data_size_o     = out_res.data_size;

  // The last payload byte always leaves the parser in the done state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_payload_o) |-> (payload_valid_o && status_o == StDone))
    else $error("last payload byte without done status");

  // A payload byte is only reported in the payload or done state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_valid_o) |-> (status_o == StPayload || status_o == StDone))
    else $error("payload byte reported outside payload phase");

  // Input is refused only while the input register holds an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_o))
    else $error("input stalled with nothing pending");

  // An item moved out of the input register is offered in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_o)
    else $error("parsed item not offered at the output");

endmodule

// ===== tb/wav_header_parser_tb.sv =====
`timescale 1ns / 1ps

module wav_header_parser_tb;

  import whp_pkg::*;

  // One row of the directed byte sequence. A row with typed set carries its
  // expected status; all other result fields of such a row are zero.
  typedef struct packed {
    logic [7:0] b;
    logic       sof;
    logic       typed;
    status_e    st;
  } byte_row_t;

  localparam int unsigned ItemTarget = 1050;
  localparam int unsigned HeaderLen  = 44;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  byte_value_i = 8'h00;
  logic        start_of_file_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        payload_valid_o;
  logic [7:0]  payload_byte_o;
  logic        last_payload_o;
  logic [2:0]  status_o;
  logic [15:0] channel_count_o;
  logic [31:0] sample_rate_o;
  logic [15:0] sample_bits_o;
  logic [31:0] data_size_o;

  // Parser state as the testbench tracks it.
  logic [5:0]  hdr_off;
  logic [31:0] shift_q;
  logic [15:0] chan_q;
  logic [31:0] rate_q;
  logic [15:0] bits_q;
  logic [31:0] size_q;
  logic [31:0] left_q;
  status_e     st_q;

  result_t     parse_results_due [$];
  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  logic        fast_input = 1'b0;
  logic        long_hold_done = 1'b0;

  status_e header_faults [5] = '{StNoRiff, StNoWave, StFmtSize, StNonPcm, StNoData};

  // Directed bytes: a stream with no start after reset, a restart in the
  // middle of the header, a bad RIFF tag, bytes ignored after the error, an
  // all-ones byte at offset zero, and the opening of a well-formed header.
  byte_row_t byte_rows [23] = '{
    '{8'h52, 1'b0, 1'b1, StHeader},
    '{8'h49, 1'b0, 1'b1, StHeader},
    '{8'h46, 1'b0, 1'b1, StHeader},
    '{8'h46, 1'b0, 1'b1, StHeader},
    '{8'h00, 1'b0, 1'b1, StHeader},
    '{8'h58, 1'b1, 1'b1, StHeader},
    '{8'h49, 1'b0, 1'b1, StHeader},
    '{8'h46, 1'b0, 1'b1, StHeader},
    '{8'h00, 1'b0, 1'b1, StNoRiff},
    '{8'hFF, 1'b0, 1'b1, StNoRiff},
    '{8'hFF, 1'b1, 1'b1, StHeader},
    '{8'h49, 1'b0, 1'b1, StHeader},
    '{8'h46, 1'b0, 1'b1, StHeader},
    '{8'h46, 1'b0, 1'b1, StNoRiff},
    '{8'h52, 1'b1, 1'b1, StHeader},
    '{8'h49, 1'b0, 1'b1, StHeader},
    '{8'h46, 1'b0, 1'b1, StHeader},
    '{8'h46, 1'b0, 1'b1, StHeader},
    '{8'hFF, 1'b0, 1'b0, StHeader},
    '{8'h00, 1'b0, 1'b0, StHeader},
    '{8'hA5, 1'b0, 1'b0, StHeader},
    '{8'h5A, 1'b0, 1'b0, StHeader},
    '{8'h57, 1'b0, 1'b0, StHeader}
  };

  wav_header_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_value_i   (byte_value_i),
    .start_of_file_i(start_of_file_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .payload_valid_o(payload_valid_o),
    .payload_byte_o (payload_byte_o),
    .last_payload_o (last_payload_o),
    .status_o       (status_o),
    .channel_count_o(channel_count_o),
    .sample_rate_o  (sample_rate_o),
    .sample_bits_o  (sample_bits_o),
    .data_size_o    (data_size_o)
  );

  // 50 MHz clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Back to header offset zero with nothing captured.
  function automatic void clear_parser();
    hdr_off = '0;
    shift_q = '0;
    chan_q  = '0;
    rate_q  = '0;
    bits_q  = '0;
    size_q  = '0;
    left_q  = '0;
    st_q    = StHeader;
  endfunction

  // Advances the tracked parser by one byte and returns the result it gives.
  function automatic result_t parse_byte(logic [7:0] b, logic sof);
    result_t r;
    r = '0;
    if (sof) begin
      clear_parser();
    end
    if (st_q == StHeader) begin
      // Header bytes shift in little-endian; fields are judged when complete.
      shift_q = {b, shift_q[31:8]};
      case (hdr_off)
        OffRiff: begin
          if (shift_q != TagRiff) st_q = StNoRiff;
        end
        OffWave: begin
          if (shift_q != TagWave) st_q = StNoWave;
        end
        OffFmtSize: begin
          if (shift_q != FmtChunkSize) st_q = StFmtSize;
        end
        OffFormat: begin
          if (shift_q[31:16] != FmtPcm) st_q = StNonPcm;
        end
        OffChannels: chan_q = shift_q[31:16];
        OffRate: rate_q = shift_q;
        OffBits: bits_q = shift_q[31:16];
        OffData: begin
          if (shift_q != TagData) st_q = StNoData;
        end
        OffLast: begin
          size_q = shift_q;
          left_q = shift_q;
          st_q = (shift_q == '0) ? StDone : StPayload;
        end
        default: ;
      endcase
      if (hdr_off < OffLast) hdr_off = hdr_off + 6'd1;
    end else if (st_q == StPayload) begin
      // Payload passes through until the count runs out.
      r.payload_valid = 1'b1;
      r.payload_byte = b;
      left_q = left_q - 32'd1;
      if (left_q == '0) begin
        r.last_payload = 1'b1;
        st_q = StDone;
      end
    end
    r.status = st_q;
    r.channel_count = chan_q;
    r.sample_rate = rate_q;
    r.sample_bits = bits_q;
    r.data_size = size_q;
    return r;
  endfunction

  // Offers one byte after a random gap and records its expected result once
  // it is taken. Valid stays high when the next item follows without a gap.
  task automatic send_item(logic [7:0] b, logic sof, logic typed = 1'b0,
                           status_e typed_st = StHeader);
    int unsigned gap;
    result_t     r;
    gap = fast_input ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_value_i <= b;
    start_of_file_i <= sof;
    do @(posedge clk_i); while (!in_ready_o);
    r = parse_byte(b, sof);
    if (typed) begin
      r = '0;
      r.status = typed_st;
    end
    parse_results_due.push_back(r);
    bytes_sent++;
  endtask

  // Sends a file: a 44-byte header, optionally with one bit of a checked
  // field flipped, then tail_len more bytes. hdr_len below 44 cuts the file
  // short inside the header.
  task automatic send_file(status_e bad, logic [15:0] ch, logic [31:0] rate,
                           logic [15:0] bits, logic [31:0] size,
                           int unsigned hdr_len, int unsigned tail_len);
    logic [7:0] hdr [HeaderLen];
    int         pos;
    for (int i = 0; i < 4; i++) begin
      hdr[i]      = TagRiff[8*i +: 8];
      hdr[4 + i]  = 8'($urandom);
      hdr[8 + i]  = TagWave[8*i +: 8];
      hdr[12 + i] = 8'($urandom);
      hdr[16 + i] = FmtChunkSize[8*i +: 8];
      hdr[24 + i] = rate[8*i +: 8];
      hdr[28 + i] = 8'($urandom);
      hdr[36 + i] = TagData[8*i +: 8];
      hdr[40 + i] = size[8*i +: 8];
    end
    for (int i = 0; i < 2; i++) begin
      hdr[20 + i] = FmtPcm[8*i +: 8];
      hdr[22 + i] = ch[8*i +: 8];
      hdr[32 + i] = 8'($urandom);
      hdr[34 + i] = bits[8*i +: 8];
    end
    case (bad)
      StNoRiff:  pos = int'(OffRiff) - int'($urandom_range(0, 3));
      StNoWave:  pos = int'(OffWave) - int'($urandom_range(0, 3));
      StFmtSize: pos = int'(OffFmtSize) - int'($urandom_range(0, 3));
      StNonPcm:  pos = int'(OffFormat) - int'($urandom_range(0, 1));
      StNoData:  pos = int'(OffData) - int'($urandom_range(0, 3));
      default:   pos = -1;
    endcase
    if (pos >= 0) begin
      hdr[pos] = hdr[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    for (int i = 0; i < hdr_len; i++) begin
      send_item(hdr[i], i == 0);
    end
    if (hdr_len == HeaderLen) begin
      for (int i = 0; i < tail_len; i++) begin
        send_item(8'($urandom), 1'b0);
      end
    end
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Checks one accepted result against the oldest expectation.
  task automatic check_result(result_t got);
    result_t want;
    if (parse_results_due.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual status %0d",
               $time, got.status);
      mismatches++;
      return;
    end
    want = parse_results_due.pop_front();
    compare_field("payload_valid", 32'(want.payload_valid), 32'(got.payload_valid));
    compare_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
    compare_field("last_payload", 32'(want.last_payload), 32'(got.last_payload));
    compare_field("status", 32'(want.status), 32'(got.status));
    compare_field("channel_count", 32'(want.channel_count), 32'(got.channel_count));
    compare_field("sample_rate", want.sample_rate, got.sample_rate);
    compare_field("sample_bits", 32'(want.sample_bits), 32'(got.sample_bits));
    compare_field("data_size", want.data_size, got.data_size);
  endtask

  // Receiver: random stalls per item, a stretch with none in the last quarter of
  // every 256 results, and one long hold so that the block backs up into its input.
  initial begin
    int unsigned stall;
    result_t     got;
    wait (rst_ni === 1'b1);
    forever begin
      if (results_seen % 256 >= 192) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 10);
      end
      if (!long_hold_done && results_seen >= 150) begin
        long_hold_done = 1'b1;
        stall = 60;
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.payload_valid = payload_valid_o;
      got.payload_byte  = payload_byte_o;
      got.last_payload  = last_payload_o;
      got.status        = status_e'(status_o);
      got.channel_count = channel_count_o;
      got.sample_rate   = sample_rate_o;
      got.sample_bits   = sample_bits_o;
      got.data_size     = data_size_o;
      check_result(got);
      results_seen++;
    end
  end

  // Sender: directed bytes, then a stream of files.
  initial begin
    int unsigned f;
    int unsigned kind;
    status_e     bad;
    logic [31:0] size;
    int unsigned hdr_len;
    int unsigned tail_len;
    clear_parser();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (byte_rows[i]) begin
      send_item(byte_rows[i].b, byte_rows[i].sof, byte_rows[i].typed, byte_rows[i].st);
    end

    f = 0;
    while (bytes_sent < ItemTarget) begin
      // Once, let the block drain completely before the next file.
      if (f == 12) begin
        in_valid_i <= 1'b0;
        while (parse_results_due.size() != 0) @(posedge clk_i);
      end
      fast_input = ($urandom_range(0, 3) == 0);
      case (f)
        // Zero data size with all fields zero, then dropped bytes.
        0: send_file(StHeader, 16'h0000, 32'h0, 16'h0000, 32'h0, HeaderLen, 3);
        // All-ones fields, a short payload and dropped bytes after it.
        1: send_file(StHeader, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd5, HeaderLen, 8);
        // Each header fault once.
        2, 3, 4, 5, 6: begin
          send_file(header_faults[f - 2], 16'($urandom), $urandom, 16'($urandom),
                    32'd4, HeaderLen, 4);
        end
        // Largest data size, cut short by the next start of file.
        7: send_file(StHeader, 16'($urandom), $urandom, 16'($urandom),
                     32'hFFFF_FFFF, HeaderLen, 6);
        // One payload byte that is also the last one.
        8: send_file(StHeader, 16'($urandom), $urandom, 16'($urandom), 32'd1,
                     HeaderLen, 1);
        default: begin
          kind = $urandom_range(0, 19);
          if (kind < 2) begin
            // Noise: raw bytes, now and then with a start of file.
            repeat ($urandom_range(1, 12)) begin
              send_item(8'($urandom), $urandom_range(0, 7) == 0);
            end
          end else begin
            bad = (kind < 6) ? header_faults[$urandom_range(0, 4)] : StHeader;
            hdr_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 43) : HeaderLen;
            case ($urandom_range(0, 9))
              0: begin
                size = 32'd0;
                tail_len = $urandom_range(0, 4);
              end
              1: begin
                size = $urandom;
                tail_len = $urandom_range(0, 8);
              end
              default: begin
                size = $urandom_range(1, 24);
                if ($urandom_range(0, 7) == 0) begin
                  tail_len = $urandom_range(0, size - 1);
                end else begin
                  tail_len = size + $urandom_range(0, 4);
                end
              end
            endcase
            if (bad != StHeader) tail_len = $urandom_range(0, 6);
            send_file(bad, 16'($urandom), $urandom, 16'($urandom), size,
                      hdr_len, tail_len);
          end
        end
      endcase
      f++;
    end

    // Drain, then give any stray result time to show up.
    in_valid_i <= 1'b0;
    while (parse_results_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
